@@ hdl/pmb_pkg.sv @@
// Shared types and constants of the polyline bending block.
package pmb_pkg;

  localparam int COS_BITS  = 18;
  localparam int Q_BITS    = 19;
  localparam int DIV_STEPS = 19;
  localparam int COS_FRAC  = 16;

  localparam logic signed [COS_BITS-1:0] COS_ONE = 18'sd65536;

  typedef enum logic [2:0] {
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_DOT0,
    OP_DOT1,
    OP_DOT2,
    OP_DEN
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_e mul_op;
    logic    mul_step;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    div_init;
    logic    div_step;
    logic    cos_upd;
    logic    update;
  } cmd_t;

  typedef struct packed {
    logic seen1;
    logic seen2;
    logic len_zero;
    logic cnt_last;
    logic is_last;
    logic out_busy;
  } status_t;

endpackage

@@ hdl/pmb_ctrl.sv @@
// Controller state machine that sequences the shared datapath units.
module pmb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pmb_pkg::status_t st_i,
  output pmb_pkg::cmd_t    cmd_o
);
  import pmb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MLOAD = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SQI   = 4'd4;
  localparam logic [3:0] S_SQR   = 4'd5;
  localparam logic [3:0] S_LCHK  = 4'd6;
  localparam logic [3:0] S_DVI   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_COS   = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;

  logic [3:0] state_q, state_d;
  mul_op_e    op_q, op_d;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_op  = op_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (st_i.seen1) begin
          op_d    = OP_SQ0;
          state_d = S_MLOAD;
        end else begin
          state_d = S_UPD;
        end
      end
      S_MLOAD: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (st_i.cnt_last) begin
          unique case (op_q)
            OP_SQ0:  begin op_d = OP_SQ1;  state_d = S_MLOAD; end
            OP_SQ1:  begin op_d = OP_SQ2;  state_d = S_MLOAD; end
            OP_SQ2:  state_d = S_SQI;
            OP_DOT0: begin op_d = OP_DOT1; state_d = S_MLOAD; end
            OP_DOT1: begin op_d = OP_DOT2; state_d = S_MLOAD; end
            OP_DOT2: begin op_d = OP_DEN;  state_d = S_MLOAD; end
            OP_DEN:  state_d = S_DVI;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        state_d         = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqrt_step = 1'b1;
        if (st_i.cnt_last) state_d = S_LCHK;
      end
      S_LCHK: begin
        // A zero-length segment gives cosine one, which never lowers the minimum.
        if (st_i.seen2 && !st_i.len_zero) begin
          op_d    = OP_DOT0;
          state_d = S_MLOAD;
        end else begin
          state_d = S_UPD;
        end
      end
      S_DVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.cnt_last) state_d = S_COS;
      end
      S_COS: begin
        cmd_o.cos_upd = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        if (!(st_i.is_last && st_i.out_busy)) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_SQ0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_CHK)
    else $error("load not followed by check");
  a_upd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> in_ready_o)
    else $error("not ready after update");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mul_step, cmd_o.sqrt_step, cmd_o.div_step, cmd_o.update}))
    else $error("two units stepped at once");

endmodule

@@ hdl/pmb_dp.sv @@
// Datapath: point registers, serial multiplier, square root, divider, result register.
module pmb_dp #(
  parameter int CB = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [CB-1:0]              point_x_i,
  input  logic signed [CB-1:0]              point_y_i,
  input  logic signed [CB-1:0]              point_z_i,
  input  logic                              last_point_i,
  input  logic                              branch_node_i,
  input  pmb_pkg::cmd_t                     cmd_i,
  output pmb_pkg::status_t                  st_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pmb_pkg::COS_BITS-1:0]      bending_energy_o,
  output logic                              too_few_points_o
);
  import pmb_pkg::*;

  localparam int MB = CB + 1;        // multiplier operand and length width
  localparam int PW = 2 * MB;
  localparam int AW = PW + 2;        // sum of three products, signed
  localparam int RW = MB + 2;        // square root remainder
  localparam int W  = 2 * CB + 20;   // divider remainder
  localparam int CW = $clog2(MB + 1);

  logic signed [CB-1:0] pt_q [3];
  logic        [CB-1:0] mag_q [3];
  logic        [2:0]    sgn_q;
  logic        [CB-1:0] pvec_q [3];
  logic        [2:0]    pneg_q;
  logic        [MB-1:0] plen_q;
  logic                 last_q, branch_q;
  logic        [1:0]    ps_q;
  logic signed [COS_BITS-1:0] min_q;

  logic        [PW-1:0] areg_q;
  logic        [MB-1:0] breg_q;
  logic                 mneg_q;
  logic signed [AW-1:0] acc_q;
  logic        [AW-2:0] num_q;
  logic                 dneg_q;
  logic        [CW-1:0] cnt_q;

  logic [2*MB-1:0] rad_q;
  logic [MB-1:0]   root_q;
  logic [RW-1:0]   rem_q;

  logic [W-1:0]      r_q, dsh_q;
  logic [Q_BITS-1:0] q_q;

  logic                  out_valid_q;
  logic [COS_BITS-1:0]   energy_q;
  logic                  few_q;

  logic signed [CB-1:0] pin [3];
  logic signed [CB:0]   dif [3];
  logic [MB-1:0] opa, opb;
  logic          oneg;
  logic [RW-1:0] rem_sh, trial;
  logic [Q_BITS-1:0] qc;
  logic signed [COS_BITS-1:0] cosv;
  logic [1:0] ps_new;
  logic signed [COS_BITS:0] ediff;
  logic few;

  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {pin[i][CB-1], pin[i]} - {pt_q[i][CB-1], pt_q[i]};
    end
  end

  always_comb begin
    opa  = '0;
    opb  = '0;
    oneg = 1'b0;
    unique case (cmd_i.mul_op)
      OP_SQ0:  begin opa = {1'b0, mag_q[0]}; opb = {1'b0, mag_q[0]}; end
      OP_SQ1:  begin opa = {1'b0, mag_q[1]}; opb = {1'b0, mag_q[1]}; end
      OP_SQ2:  begin opa = {1'b0, mag_q[2]}; opb = {1'b0, mag_q[2]}; end
      OP_DOT0: begin opa = {1'b0, pvec_q[0]}; opb = {1'b0, mag_q[0]};
                     oneg = pneg_q[0] ^ sgn_q[0]; end
      OP_DOT1: begin opa = {1'b0, pvec_q[1]}; opb = {1'b0, mag_q[1]};
                     oneg = pneg_q[1] ^ sgn_q[1]; end
      OP_DOT2: begin opa = {1'b0, pvec_q[2]}; opb = {1'b0, mag_q[2]};
                     oneg = pneg_q[2] ^ sgn_q[2]; end
      OP_DEN:  begin opa = plen_q; opb = root_q; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign rem_sh = {rem_q[RW-3:0], rad_q[2*MB-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  assign qc   = (q_q > Q_BITS'(COS_ONE)) ? Q_BITS'(COS_ONE) : q_q;
  assign cosv = dneg_q ? -$signed(qc[COS_BITS-1:0]) : $signed(qc[COS_BITS-1:0]);

  assign ps_new = (ps_q == 2'd3) ? 2'd3 : ps_q + 2'd1;
  assign few    = (ps_new != 2'd3);
  assign ediff  = (COS_BITS + 1)'(COS_ONE) - {min_q[COS_BITS-1], min_q};

  // Payload and arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        pt_q[i]  <= pin[i];
        mag_q[i] <= dif[i][CB] ? CB'(-dif[i]) : dif[i][CB-1:0];
        sgn_q[i] <= dif[i][CB];
      end
      last_q   <= last_point_i;
      branch_q <= branch_node_i;
    end
    if (cmd_i.mul_start) begin
      areg_q <= PW'(opa);
      breg_q <= opb;
      mneg_q <= oneg;
      if (cmd_i.mul_op == OP_SQ0 || cmd_i.mul_op == OP_DOT0 || cmd_i.mul_op == OP_DEN) begin
        acc_q <= '0;
      end
      if (cmd_i.mul_op == OP_DEN) begin
        num_q  <= acc_q[AW-1] ? (AW-1)'(-acc_q) : acc_q[AW-2:0];
        dneg_q <= acc_q[AW-1];
      end
    end
    if (cmd_i.mul_step) begin
      if (breg_q[0]) begin
        acc_q <= mneg_q ? acc_q - $signed({2'b00, areg_q})
                        : acc_q + $signed({2'b00, areg_q});
      end
      areg_q <= {areg_q[PW-2:0], 1'b0};
      breg_q <= {1'b0, breg_q[MB-1:1]};
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_q[2*MB-1:0];
      root_q <= '0;
      rem_q  <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[2*MB-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[MB-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[MB-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      r_q   <= {1'b0, num_q, {COS_FRAC{1'b0}}};
      dsh_q <= {acc_q[PW-1:0], {(DIV_STEPS-1){1'b0}}};
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      dsh_q <= {1'b0, dsh_q[W-1:1]};
      if (dsh_q <= r_q) begin
        r_q <= r_q - dsh_q;
        q_q <= {q_q[Q_BITS-2:0], 1'b1};
      end else begin
        q_q <= {q_q[Q_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.update && ps_q != 2'd0) begin
      pvec_q <= mag_q;
      pneg_q <= sgn_q;
      plen_q <= root_q;
    end
    if (cmd_i.update && last_q) begin
      energy_q <= (few || branch_q) ? '0 : ediff[COS_BITS-1:0];
      few_q    <= few;
    end
  end

  // Control state: counter, window count, running minimum, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ps_q        <= 2'd0;
      min_q       <= COS_ONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mul_start) begin
        cnt_q <= CW'(MB);
      end else if (cmd_i.sqrt_init) begin
        cnt_q <= CW'(MB);
      end else if (cmd_i.div_init) begin
        cnt_q <= CW'(DIV_STEPS);
      end else if (cmd_i.mul_step || cmd_i.sqrt_step || cmd_i.div_step) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.cos_upd && cosv < min_q) begin
        min_q <= cosv;
      end
      if (cmd_i.update) begin
        if (last_q) begin
          ps_q  <= 2'd0;
          min_q <= COS_ONE;
        end else begin
          ps_q <= ps_new;
        end
      end
      if (cmd_i.update && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.seen1    = (ps_q != 2'd0);
  assign st_o.seen2    = (ps_q[1] == 1'b1);
  assign st_o.len_zero = (root_q == '0) || (plen_q == '0);
  assign st_o.cnt_last = (cnt_q == CW'(1));
  assign st_o.is_last  = last_q;
  assign st_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign bending_energy_o = energy_q;
  assign too_few_points_o = few_q;

  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= COS_ONE && min_q >= -COS_ONE)
    else $error("minimum cosine out of range");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && last_q) |=> out_valid_q)
    else $error("result not presented after last item");
  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && !last_q && ps_q == 2'd3) |=> ps_q == 2'd3)
    else $error("point count left saturation");

endmodule

@@ hdl/polyline_max_bending_top.sv @@
// Polyline bending top level: takes 3D points one item at a time and reports, on the
// last point of a window, one minus the smallest cosine between successive segments
// (unsigned Q2.16), or zero with too_few_points set when fewer than three points came,
// or zero when branch_node is set with the last point. The first point of a window
// only loads its coordinates. The second point, and any point where this or the
// previous segment has zero length, also runs three squares on the shared
// one-bit-per-cycle multiplier and a bit-serial square root. Every later point
// adds three dot terms, the length product and a 19-step divider. A finished result
// sits in an output register, so points keep coming while it waits; only the next
// last point holds in its final cycle until the waiting result has been taken.
module polyline_max_bending_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic signed [COORD_BITS-1:0]  point_z_i,
  input  logic                          last_point_i,
  input  logic                          branch_node_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pmb_pkg::COS_BITS-1:0]  bending_energy_o,
  output logic                          too_few_points_o
);
  import pmb_pkg::*;

  cmd_t    cmd;
  status_t st;

  pmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pmb_dp #(
    .CB (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .point_z_i        (point_z_i),
    .last_point_i     (last_point_i),
    .branch_node_i    (branch_node_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bending_energy_o (bending_energy_o),
    .too_few_points_o (too_few_points_o)
  );

endmodule
